FILE: hw/rtl/tsrs_pkg.sv
// Shared constants, types and helper functions of the tile shape rasterizer.
`timescale 1ns / 1ps

package tsrs_pkg;

    // Tile geometry and field widths
    localparam int TILE_SIZE  = 16;
    localparam int COORD_W    = 4;
    localparam int COLOR_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NROWS      = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_KIND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_COLOR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_COLOR  = 3'd6;

    // Edge mask bits and the single-edge codes that orient the taper
    localparam int EDGE_UP_BIT    = 0;
    localparam int EDGE_DOWN_BIT  = 1;
    localparam int EDGE_LEFT_BIT  = 2;
    localparam int EDGE_RIGHT_BIT = 3;
    localparam logic [3:0] EDGE_ONLY_UP    = 4'b0001;
    localparam logic [3:0] EDGE_ONLY_LEFT  = 4'b0100;
    localparam logic [3:0] EDGE_ONLY_RIGHT = 4'b1000;

    // Shape select
    localparam logic SHAPE_BOX   = 1'b0;
    localparam logic SHAPE_TAPER = 1'b1;

    // Rows evaluated per pixel
    localparam int ROW_ABOVE = 0;
    localparam int ROW_MID   = 1;
    localparam int ROW_BELOW = 2;

    // Taper profile
    localparam int TAPER_SHRINK = 5;
    localparam int TAPER_CENTER = TILE_SIZE / 2;
    localparam int TAPER_MAX    = TILE_SIZE / 2 - 1;
    localparam int TAPER_DEN    = (TILE_SIZE - 1) * (TILE_SIZE - 1);

    // Corner circle arithmetic: offset 2a+1-2r, its square, sum of two squares
    localparam int OFF_W = COORD_W + 3;
    localparam int SQ_W  = 2 * (COORD_W + 1);
    localparam int SUM_W = SQ_W + 1;

    typedef logic [COORD_W-1:0]              t_coord;
    typedef logic [COLOR_W-1:0]              t_color;
    typedef logic signed [OFF_W-1:0]         t_off;
    typedef logic [SQ_W-1:0]                 t_sq;
    typedef logic [TILE_SIZE-1:0][COORD_W-1:0] t_bound_tab;

    // Per-row geometry after the first compute stage
    typedef struct packed {
        logic edge_cov;   // row lies beyond the tile, counts as covered
        logic y_core;     // row inside the box core
        logic arm;        // row covered by an arm
        logic taper;      // row covered by the taper
        t_off dy_t;       // offset from the top core edge
        t_off dy_b;       // offset from the bottom core edge
    } t_row_geo;

    // Per-row data after squaring
    typedef struct packed {
        logic edge_cov;
        logic y_core;
        logic arm;
        logic taper;
        logic near_t;     // within radius of the top core edge
        logic near_b;     // within radius of the bottom core edge
        t_sq  sq_t;
        t_sq  sq_b;
    } t_row_sq;

    // Lower bound of the taper span at distance i from the connected edge
    function automatic t_bound_tab taper_lo_tab();
        int half;
        t_bound_tab tab;
        for (int i = 0; i < TILE_SIZE; i++) begin
            half   = TAPER_MAX - (i * i * TAPER_SHRINK) / TAPER_DEN;
            tab[i] = COORD_W'(TAPER_CENTER - half);
        end
        return tab;
    endfunction

    // Upper bound of the taper span at distance i from the connected edge
    function automatic t_bound_tab taper_hi_tab();
        int half;
        t_bound_tab tab;
        for (int i = 0; i < TILE_SIZE; i++) begin
            half   = TAPER_MAX - (i * i * TAPER_SHRINK) / TAPER_DEN;
            tab[i] = COORD_W'(TAPER_MAX + half);
        end
        return tab;
    endfunction

    localparam t_bound_tab TAPER_LO = taper_lo_tab();
    localparam t_bound_tab TAPER_HI = taper_hi_tab();

    // 2a + 1 - 2r, negative exactly when a < r
    function automatic t_off corner_off(t_coord a, t_coord rad);
        return $signed({2'b00, a, 1'b1}) - $signed({2'b00, rad, 1'b0});
    endfunction

    // Square of a corner offset; magnitude stays below 2^(COORD_W+1)
    function automatic t_sq off_square(t_off v);
        logic signed [2*OFF_W-1:0] prod;
        prod = v * v;
        return prod[SQ_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/tile_shape_rasterize_shade.sv
// Top level of the tile shape rasterizer and shader.
`timescale 1ns / 1ps

// Tile shape rasterizer and shader.
// A pixel (i_pixel_x, i_pixel_y) of a 16x16 tile is taken at a rising edge
// with start high and busy low. busy stays low: a new pixel may be issued
// in every cycle, one pixel per clock sustained.
// o_strobe rises after the valid bit has passed r1_v, r2_v and r3_v, and
// is high for one cycle with o_covered and o_pixel_color (zero when not
// covered); the result is taken at the edge that ends the strobe. Results
// come out in issue order. The pipeline has four register stages: input
// capture, row geometry and taper lookup, corner offset squaring, and the
// output stage of coverage and color select.
// The receiver cannot stall, so no result is ever held back.
// Configuration uses its own valid/ready write channel (o_cfg_ready is
// always high); write only while no pixel is in flight. Index 7 is ignored.
// Synchronous reset clears the valid bits and config registers; pixel data registers are not reset.
module tile_shape_rasterize_shade (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tsrs_pkg::COORD_W-1:0]    i_pixel_x,
    input  logic [tsrs_pkg::COORD_W-1:0]    i_pixel_y,
    output logic                            o_strobe,
    output logic                            o_covered,
    output logic [tsrs_pkg::COLOR_W-1:0]    o_pixel_color,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tsrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsrs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam tsrs_pkg::t_coord TMAX = tsrs_pkg::COORD_W'(tsrs_pkg::TILE_SIZE - 1);

    // Configuration registers
    logic                 r_shape_kind;
    logic [3:0]           r_edge_mask;
    tsrs_pkg::t_coord     r_margin;
    tsrs_pkg::t_coord     r_radius;
    logic [tsrs_pkg::SUM_W-1:0] r_rad4;   // 4 r^2, kept with the radius
    tsrs_pkg::t_color     r_body_color;
    tsrs_pkg::t_color     r_top_color;
    tsrs_pkg::t_color     r_bottom_color;
    logic [2*tsrs_pkg::COORD_W-1:0] n_rad_sq;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;
    assign n_rad_sq    = i_cfg_data[tsrs_pkg::COORD_W-1:0] * i_cfg_data[tsrs_pkg::COORD_W-1:0];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_kind   <= 1'b0;
            r_edge_mask    <= '0;
            r_margin       <= '0;
            r_radius       <= '0;
            r_rad4         <= '0;
            r_body_color   <= '0;
            r_top_color    <= '0;
            r_bottom_color <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tsrs_pkg::REG_SHAPE_KIND:    r_shape_kind   <= i_cfg_data[0];
                tsrs_pkg::REG_EDGE_MASK:     r_edge_mask    <= i_cfg_data[3:0];
                tsrs_pkg::REG_MARGIN:        r_margin <= i_cfg_data[tsrs_pkg::COORD_W-1:0];
                tsrs_pkg::REG_CORNER_RADIUS: begin
                    r_radius <= i_cfg_data[tsrs_pkg::COORD_W-1:0];
                    r_rad4   <= {1'b0, n_rad_sq, 2'b00};
                end
                tsrs_pkg::REG_BODY_COLOR:    r_body_color   <= i_cfg_data;
                tsrs_pkg::REG_TOP_COLOR:     r_top_color    <= i_cfg_data;
                tsrs_pkg::REG_BOTTOM_COLOR:  r_bottom_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic edge_up, edge_dn, edge_lf, edge_rt;
    assign edge_up = r_edge_mask[tsrs_pkg::EDGE_UP_BIT];
    assign edge_dn = r_edge_mask[tsrs_pkg::EDGE_DOWN_BIT];
    assign edge_lf = r_edge_mask[tsrs_pkg::EDGE_LEFT_BIT];
    assign edge_rt = r_edge_mask[tsrs_pkg::EDGE_RIGHT_BIT];

    // Stage 1: capture the pixel beat
    logic             r1_v;
    tsrs_pkg::t_coord r1_x;
    tsrs_pkg::t_coord r1_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x <= i_pixel_x;
        r1_y <= i_pixel_y;
    end

    // Stage 2 logic: core bounds, arms, taper span and corner offsets
    tsrs_pkg::t_coord   core_hi;
    logic               core_ok;
    logic               x_core;
    tsrs_pkg::t_off     n_dx_l, n_dx_r;
    tsrs_pkg::t_row_geo n_geo [tsrs_pkg::NROWS];

    assign core_hi = TMAX - r_margin;
    assign core_ok = r_margin <= core_hi;
    assign x_core  = core_ok && (r1_x >= r_margin) && (r1_x <= core_hi);
    assign n_dx_l  = tsrs_pkg::corner_off(r1_x - r_margin, r_radius);
    assign n_dx_r  = tsrs_pkg::corner_off(core_hi - r1_x, r_radius);

    always_comb begin
        tsrs_pkg::t_coord yk;
        tsrs_pkg::t_coord ti;
        tsrs_pkg::t_coord tj;
        logic             yc;
        for (int k = 0; k < tsrs_pkg::NROWS; k++) begin
            yk = tsrs_pkg::t_coord'(r1_y + tsrs_pkg::COORD_W'(k) - tsrs_pkg::COORD_W'(1));
            yc = core_ok && (yk >= r_margin) && (yk <= core_hi);

            if (k == tsrs_pkg::ROW_ABOVE) begin
                n_geo[k].edge_cov = (r1_y == '0);
            end else if (k == tsrs_pkg::ROW_BELOW) begin
                n_geo[k].edge_cov = (r1_y == TMAX);
            end else begin
                n_geo[k].edge_cov = 1'b0;
            end
            n_geo[k].y_core = yc;
            n_geo[k].arm =
                (x_core && ((edge_up && (yk < r_margin)) ||
                            (edge_dn && ((TMAX - yk) < r_margin)))) ||
                (yc && ((edge_lf && (r1_x < r_margin)) ||
                        (edge_rt && ((TMAX - r1_x) < r_margin))));
            n_geo[k].dy_t = tsrs_pkg::corner_off(yk - r_margin, r_radius);
            n_geo[k].dy_b = tsrs_pkg::corner_off(core_hi - yk, r_radius);

            // Taper axis: distance from the connected edge and position across
            priority if (r_edge_mask == tsrs_pkg::EDGE_ONLY_LEFT) begin
                ti = r1_x;
                tj = yk;
            end else if (r_edge_mask == tsrs_pkg::EDGE_ONLY_RIGHT) begin
                ti = TMAX - r1_x;
                tj = yk;
            end else if (r_edge_mask == tsrs_pkg::EDGE_ONLY_UP) begin
                ti = yk;
                tj = r1_x;
            end else begin
                ti = TMAX - yk;
                tj = r1_x;
            end
            n_geo[k].taper = (tj >= tsrs_pkg::TAPER_LO[ti]) && (tj <= tsrs_pkg::TAPER_HI[ti]);
        end
    end

    logic               r2_v;
    logic               r2_x_core;
    tsrs_pkg::t_off     r2_dx_l, r2_dx_r;
    tsrs_pkg::t_row_geo r2_geo [tsrs_pkg::NROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_x_core <= x_core;
        r2_dx_l   <= n_dx_l;
        r2_dx_r   <= n_dx_r;
        for (int k = 0; k < tsrs_pkg::NROWS; k++) begin
            r2_geo[k] <= n_geo[k];
        end
    end

    // Stage 3: square the corner offsets
    logic              r3_v;
    logic              r3_x_core;
    logic              r3_near_l, r3_near_r;
    tsrs_pkg::t_sq     r3_sq_l, r3_sq_r;
    tsrs_pkg::t_row_sq r3_row [tsrs_pkg::NROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_x_core <= r2_x_core;
        r3_near_l <= r2_dx_l[tsrs_pkg::OFF_W-1];
        r3_near_r <= r2_dx_r[tsrs_pkg::OFF_W-1];
        r3_sq_l   <= tsrs_pkg::off_square(r2_dx_l);
        r3_sq_r   <= tsrs_pkg::off_square(r2_dx_r);
        for (int k = 0; k < tsrs_pkg::NROWS; k++) begin
            r3_row[k].edge_cov <= r2_geo[k].edge_cov;
            r3_row[k].y_core   <= r2_geo[k].y_core;
            r3_row[k].arm      <= r2_geo[k].arm;
            r3_row[k].taper    <= r2_geo[k].taper;
            r3_row[k].near_t   <= r2_geo[k].dy_t[tsrs_pkg::OFF_W-1];
            r3_row[k].near_b   <= r2_geo[k].dy_b[tsrs_pkg::OFF_W-1];
            r3_row[k].sq_t     <= tsrs_pkg::off_square(r2_geo[k].dy_t);
            r3_row[k].sq_b     <= tsrs_pkg::off_square(r2_geo[k].dy_b);
        end
    end

    // Stage 4 logic: circle tests, row coverage and color select
    logic free_tl, free_tr, free_bl, free_br;
    logic row_cov [tsrs_pkg::NROWS];
    tsrs_pkg::t_color n_color;

    assign free_tl = !edge_up && !edge_lf;
    assign free_tr = !edge_up && !edge_rt;
    assign free_bl = !edge_dn && !edge_lf;
    assign free_br = !edge_dn && !edge_rt;

    always_comb begin
        logic in_tl, in_tr, in_bl, in_br;
        logic drop;
        for (int k = 0; k < tsrs_pkg::NROWS; k++) begin
            in_tl = ({1'b0, r3_sq_l} + {1'b0, r3_row[k].sq_t}) <= r_rad4;
            in_tr = ({1'b0, r3_sq_r} + {1'b0, r3_row[k].sq_t}) <= r_rad4;
            in_bl = ({1'b0, r3_sq_l} + {1'b0, r3_row[k].sq_b}) <= r_rad4;
            in_br = ({1'b0, r3_sq_r} + {1'b0, r3_row[k].sq_b}) <= r_rad4;
            drop  = (free_tl && r3_near_l && r3_row[k].near_t && !in_tl) ||
                    (free_tr && r3_near_r && r3_row[k].near_t && !in_tr) ||
                    (free_bl && r3_near_l && r3_row[k].near_b && !in_bl) ||
                    (free_br && r3_near_r && r3_row[k].near_b && !in_br);
            if (r_shape_kind == tsrs_pkg::SHAPE_TAPER) begin
                row_cov[k] = r3_row[k].edge_cov || r3_row[k].taper;
            end else begin
                row_cov[k] = r3_row[k].edge_cov || r3_row[k].arm ||
                             (r3_x_core && r3_row[k].y_core && !drop);
            end
        end
    end

    always_comb begin
        priority if (!row_cov[tsrs_pkg::ROW_MID]) begin
            n_color = '0;
        end else if (!row_cov[tsrs_pkg::ROW_ABOVE]) begin
            n_color = r_top_color;
        end else if (!row_cov[tsrs_pkg::ROW_BELOW]) begin
            n_color = r_bottom_color;
        end else begin
            n_color = r_body_color;
        end
    end

    // Output register: one result beat per strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_covered     <= row_cov[tsrs_pkg::ROW_MID];
        o_pixel_color <= n_color;
    end

    // Every accepted pixel gives a result beat on o_strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted pixel produced no result");

    // No result without a matching accepted pixel
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result without an accepted pixel");

    // The pipeline is empty right after reset
    a_reset_flush: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_strobe && !r3_v && !r2_v && !r1_v)
        else $error("pipeline not flushed by reset");

    // An uncovered pixel carries no color
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_covered) |-> (o_pixel_color == '0))
        else $error("uncovered pixel with nonzero color");

endmodule
